@@ rtl/core/tal_pkg.sv @@
// ---------------------------------------------------------------------------
// tal_pkg
// types, register map and helpers shared by the tlv area locator modules
// ---------------------------------------------------------------------------
package tal_pkg;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int OUT_W   = 13;
	localparam int CFG_W   = 14;
	localparam int SUM_W   = 15;
	localparam int LEN_W   = 32;
	localparam int NEXT_W  = 34;

	localparam logic [2:0] REG_AREA_START  = 3'd0;
	localparam logic [2:0] REG_AREA_SIZE   = 3'd1;
	localparam logic [2:0] REG_TAG_WIDTH   = 3'd2;
	localparam logic [2:0] REG_LEN_WIDTH   = 3'd3;
	localparam logic [2:0] REG_BIG_ENDIAN  = 3'd4;

	localparam logic [1:0] WCODE_ONE = 2'd0;
	localparam logic [1:0] WCODE_TWO = 2'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [OUT_W-1:0] tlv_start;
		logic [OUT_W-1:0] tlv_size;
	} out_item_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] area_start;
		logic signed [CFG_W-1:0] area_size;
		logic [1:0]              tag_width_code;
		logic [1:0]              length_width_code;
		logic                    big_endian;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DECIDE,
		ST_SCAN,
		ST_HDR,
		ST_RD,
		ST_ACC,
		ST_STEP,
		ST_END,
		ST_EMIT
	} tal_state_t;

	typedef struct packed {
		logic load_en;
		logic set_fixed;
		logic set_none;
		logic start_first;
		logic init_auto;
		logic scan_first;
		logic clr_len;
		logic acc;
		logic advance;
		logic done_auto;
		logic done_start;
		logic finish_auto;
		logic load_out;
	} tal_cmd_t;

	typedef struct packed {
		logic last_acc;
		logic mode_fixed;
		logic mode_start;
		logic start_fits;
		logic hdr_fits;
		logic last_len_byte;
		logic next_fits;
		logic scan_more;
		logic out_free;
	} tal_stat_t;

	// field width in bytes
	function automatic logic [2:0] width_of(input logic [1:0] code);
		logic [2:0] w;
		case (code)
			WCODE_ONE: w = 3'd1;
			WCODE_TWO: w = 3'd2;
			default:   w = 3'd4;
		endcase
		return w;
	endfunction

	// field width in bytes minus one
	function automatic logic [1:0] width_m1(input logic [1:0] code);
		logic [1:0] w;
		case (code)
			WCODE_ONE: w = 2'd0;
			WCODE_TWO: w = 2'd1;
			default:   w = 2'd3;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/tal_regs.sv @@
// ---------------------------------------------------------------------------
// tal_regs
// apb configuration registers of the tlv area locator
// ---------------------------------------------------------------------------
module tal_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tal_pkg::PADDR_W-1:0]   paddr,
	input  logic [tal_pkg::PDATA_W-1:0]   pwdata,
	output logic [tal_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output tal_pkg::cfg_t                 cfg
);
	import tal_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_start        <= '1;
			cfg_q.area_size         <= '1;
			cfg_q.tag_width_code    <= WCODE_ONE;
			cfg_q.length_width_code <= WCODE_ONE;
			cfg_q.big_endian        <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_AREA_START: cfg_q.area_start        <= pwdata[CFG_W-1:0];
				REG_AREA_SIZE:  cfg_q.area_size         <= pwdata[CFG_W-1:0];
				REG_TAG_WIDTH:  cfg_q.tag_width_code    <= pwdata[1:0];
				REG_LEN_WIDTH:  cfg_q.length_width_code <= pwdata[1:0];
				REG_BIG_ENDIAN: cfg_q.big_endian        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_AREA_START: prdata = PDATA_W'(cfg_q.area_start);
			REG_AREA_SIZE:  prdata = PDATA_W'(cfg_q.area_size);
			REG_TAG_WIDTH:  prdata = PDATA_W'(cfg_q.tag_width_code);
			REG_LEN_WIDTH:  prdata = PDATA_W'(cfg_q.length_width_code);
			REG_BIG_ENDIAN: prdata = PDATA_W'(cfg_q.big_endian);
			default:        prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/tal_ctrl.sv @@
// ---------------------------------------------------------------------------
// tal_ctrl
// sequencer for loading, chain walking and result hand-off
// ---------------------------------------------------------------------------
module tal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  tal_pkg::tal_stat_t stat,
	output tal_pkg::tal_cmd_t  cmd
);
	import tal_pkg::*;

	tal_state_t state_q;
	tal_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_LOAD: begin
				if (stat.last_acc) state_nx = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.mode_fixed) begin
					state_nx = ST_EMIT;
				end else if (stat.mode_start) begin
					state_nx = stat.start_fits ? ST_HDR : ST_EMIT;
				end else begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: state_nx = stat.scan_more ? ST_HDR : ST_EMIT;
			ST_HDR:  state_nx = stat.hdr_fits ? ST_RD : ST_END;
			ST_RD:   state_nx = ST_ACC;
			ST_ACC:  state_nx = stat.last_len_byte ? ST_STEP : ST_RD;
			ST_STEP: state_nx = stat.next_fits ? ST_HDR : ST_END;
			ST_END: begin
				if (stat.mode_fixed || stat.mode_start) begin
					state_nx = ST_EMIT;
				end else begin
					state_nx = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) state_nx = ST_LOAD;
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD: cmd.load_en = 1'b1;
			ST_DECIDE: begin
				if (stat.mode_fixed) begin
					cmd.set_fixed = 1'b1;
				end else if (stat.mode_start) begin
					cmd.start_first = stat.start_fits;
					cmd.set_none    = ~stat.start_fits;
				end else begin
					cmd.init_auto = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan_first  = stat.scan_more;
				cmd.finish_auto = ~stat.scan_more;
			end
			ST_HDR:  cmd.clr_len = 1'b1;
			ST_RD: ;
			ST_ACC:  cmd.acc = 1'b1;
			ST_STEP: cmd.advance = stat.next_fits;
			ST_END: begin
				if (stat.mode_fixed || stat.mode_start) begin
					cmd.done_start = 1'b1;
				end else begin
					cmd.done_auto = 1'b1;
				end
			end
			ST_EMIT: cmd.load_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/tal_dp.sv @@
// ---------------------------------------------------------------------------
// tal_dp
// byte store, chain walk registers and output register
// ---------------------------------------------------------------------------
module tal_dp #(
	parameter int MAX_BYTES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tal_pkg::cfg_t      cfg,
	input  logic               in_valid,
	input  tal_pkg::in_item_t  in_data,
	input  logic               out_stall,
	input  tal_pkg::tal_cmd_t  cmd,
	output tal_pkg::tal_stat_t stat,
	output logic               out_valid,
	output tal_pkg::out_item_t out_data
);
	import tal_pkg::*;

	localparam int ADDR_W = $clog2(MAX_BYTES);
	localparam int CNT_W  = $clog2(MAX_BYTES + 1);

	logic [7:0]        mem [MAX_BYTES];
	logic [7:0]        rd_data_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  first_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  best_st_q;
	logic [CNT_W-1:0]  best_sz_q;
	logic [LEN_W-1:0]  len_q;
	logic [1:0]        idx_q;
	out_item_t         res_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              in_acc;
	logic              room;
	logic [2:0]        tw;
	logic [2:0]        lw;
	logic [3:0]        hdr;
	logic [1:0]        off;
	logic [CNT_W-1:0]  rd_addr_full;
	logic [ADDR_W-1:0] rd_addr;
	logic [NEXT_W-1:0] hdr_end;
	logic [NEXT_W-1:0] next_end;
	logic [CNT_W-1:0]  chain_len;
	logic [OUT_W-1:0]  start_u;
	logic [OUT_W-1:0]  size_u;
	logic              fixed_fits;

	assign in_acc = in_valid & cmd.load_en;
	assign room   = cnt_q < CNT_W'(MAX_BYTES);
	assign tw     = width_of(cfg.tag_width_code);
	assign lw     = width_of(cfg.length_width_code);
	assign hdr    = {1'b0, tw} + {1'b0, lw};
	assign off    = cfg.big_endian ? idx_q : (width_m1(cfg.length_width_code) - idx_q);

	assign rd_addr_full = pos_q + CNT_W'(tw) + CNT_W'(off);
	assign rd_addr      = rd_addr_full[ADDR_W-1:0];

	assign hdr_end   = NEXT_W'(pos_q) + NEXT_W'(hdr);
	assign next_end  = hdr_end + NEXT_W'(len_q);
	assign chain_len = pos_q - first_q;

	assign start_u    = cfg.area_start[OUT_W-1:0];
	assign size_u     = cfg.area_size[OUT_W-1:0];
	assign fixed_fits = (SUM_W'(start_u) + SUM_W'(size_u)) <= SUM_W'(total_q);

	always_comb begin
		stat.last_acc      = in_acc & in_data.last_byte;
		stat.mode_fixed    = ~cfg.area_start[CFG_W-1] & ~cfg.area_size[CFG_W-1];
		stat.mode_start    = ~cfg.area_start[CFG_W-1] & cfg.area_size[CFG_W-1];
		stat.start_fits    = SUM_W'(start_u) <= SUM_W'(total_q);
		stat.hdr_fits      = hdr_end <= NEXT_W'(total_q);
		stat.last_len_byte = idx_q == width_m1(cfg.length_width_code);
		stat.next_fits     = next_end <= NEXT_W'(total_q);
		stat.scan_more     = scan_q < (total_q - best_sz_q);
		stat.out_free      = ~out_valid_q | ~out_stall;
	end

	// byte store
	always_ff @(posedge clk) begin
		if (in_acc && room) begin
			mem[cnt_q[ADDR_W-1:0]] <= in_data.data_byte;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (in_data.last_byte) begin
					cnt_q <= '0;
				end else if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.last_byte) begin
			total_q <= room ? cnt_q + 1'b1 : cnt_q;
		end
		if (cmd.set_fixed) begin
			if (fixed_fits) begin
				res_q <= '{found: 1'b1, tlv_start: start_u, tlv_size: size_u};
			end else begin
				res_q <= '0;
			end
		end
		if (cmd.set_none) begin
			res_q <= '0;
		end
		if (cmd.start_first) begin
			pos_q   <= CNT_W'(start_u);
			first_q <= CNT_W'(start_u);
		end
		if (cmd.init_auto) begin
			best_st_q <= '0;
			best_sz_q <= '0;
			scan_q    <= '0;
		end
		if (cmd.scan_first) begin
			pos_q   <= scan_q;
			first_q <= scan_q;
		end
		if (cmd.clr_len) begin
			len_q <= '0;
			idx_q <= '0;
		end
		if (cmd.acc) begin
			len_q <= {len_q[LEN_W-9:0], rd_data_q};
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.advance) begin
			pos_q <= next_end[CNT_W-1:0];
		end
		if (cmd.done_auto) begin
			if (chain_len > best_sz_q) begin
				best_st_q <= first_q;
				best_sz_q <= chain_len;
			end
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.done_start) begin
			res_q <= '{found: 1'b1, tlv_start: OUT_W'(first_q), tlv_size: OUT_W'(chain_len)};
		end
		if (cmd.finish_auto) begin
			res_q.found     <= best_sz_q != '0;
			res_q.tlv_start <= (best_sz_q != '0) ? OUT_W'(best_st_q) : '0;
			res_q.tlv_size  <= OUT_W'(best_sz_q);
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/tlv_area_locator.sv @@
// ---------------------------------------------------------------------------
// tlv_area_locator
// loads a data area byte by byte and locates the tlv area inside it
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid / in_stall   | in_data  (data_byte, last_byte)
//  out      | output    | out_valid / out_stall | out_data (found, tlv_start, tlv_size)
//  apb      | input     | psel, penable, pready | paddr, pwdata, prdata
//
// bytes load at one per cycle into the byte store; after the last byte the
// input is stalled while the result is worked out, then reopens
// fixed area: decide, then emit; each tlv element walked: header check, a
// read and an accumulate state per length byte via the single read port of
// the byte store, then a step; auto search adds scan and end states per start tried
// a pending result waits in the output register while the next area loads
// ---------------------------------------------------------------------------
module tlv_area_locator #(
	parameter int MAX_BYTES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tal_pkg::PADDR_W-1:0]   paddr,
	input  logic [tal_pkg::PDATA_W-1:0]   pwdata,
	output logic [tal_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tal_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tal_pkg::out_item_t            out_data
);
	import tal_pkg::*;

	cfg_t      cfg;
	tal_cmd_t  cmd;
	tal_stat_t stat;

	assign in_stall = ~cmd.load_en;

	tal_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tal_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	tal_dp #(
		.MAX_BYTES (MAX_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for tlv_area_locator. A short directed part runs first: single-byte
// areas, extreme start and size values, width code 3 with little-endian
// lengths, and a fixed start that equals the data size. Random phases follow.
// Each phase sets every register to new values. It then loads areas that are
// mostly well-formed tlv chains with a few noise areas, including areas that
// overflow the byte store. Every request is mirrored into a local model of
// the store and the search. Each result is compared field by field with the
// oldest expected result.
// ---------------------------------------------------------------------------
module tb_top;
	import tal_pkg::*;

	localparam int STORE_DEPTH = 256;

	typedef struct {
		bit          is_write;
		logic [2:0]  reg_sel;
		logic [31:0] wdata;
		in_item_t    req;
		bit          typed;
		out_item_t   result;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;

	// local model of the block
	logic [7:0] byte_mirror [STORE_DEPTH];
	int         bytes_held;
	int         cfg_start;
	int         cfg_size;
	logic [1:0] cfg_tw;
	logic [1:0] cfg_lw;
	logic       cfg_be;

	out_item_t  area_results_due [$];
	logic [7:0] area_bytes [$];
	row_t       dir_rows [$];
	bit         row_typed;
	out_item_t  row_result;
	bit         quiet;
	bit         hold_req;
	int         mismatches;

	tlv_area_locator #(
		.MAX_BYTES(STORE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[tlv_area_locator] ERROR");
		$finish;
	end

	function automatic int field_bytes(logic [1:0] code);
		case (code)
			WCODE_ONE: return 1;
			WCODE_TWO: return 2;
			default:   return 4;
		endcase
	endfunction

	function automatic longint length_at(int pos, int nb);
		longint v;
		int     k;
		int     p;
		v = 0;
		for (k = 0; k < nb; k++) begin
			p = cfg_be ? pos + k : pos + nb - 1 - k;
			v = v << 8;
			if (p < STORE_DEPTH)
				v = v | longint'(byte_mirror[p]);
		end
		return v;
	endfunction

	function automatic int chain_span(int total, int first);
		longint tw;
		longint lw;
		longint pos;
		longint nxt;
		tw = field_bytes(cfg_tw);
		lw = field_bytes(cfg_lw);
		pos = first;
		while (pos + tw + lw <= total) begin
			nxt = pos + tw + lw + length_at(int'(pos + tw), int'(lw));
			if (nxt > total)
				break;
			pos = nxt;
		end
		return int'(pos - first);
	endfunction

	function automatic out_item_t locate_area(int total);
		out_item_t r;
		int        pos;
		int        len;
		int        st;
		int        sz;
		r = '0;
		st = 0;
		sz = 0;
		if (cfg_start >= 0 && cfg_size >= 0) begin
			if (cfg_start + cfg_size <= total) begin
				r.found = 1'b1;
				st = cfg_start;
				sz = cfg_size;
			end
		end else if (cfg_start >= 0) begin
			if (cfg_start <= total) begin
				r.found = 1'b1;
				st = cfg_start;
				sz = chain_span(total, cfg_start);
			end
		end else begin
			for (pos = 0; pos < total - sz; pos++) begin
				len = chain_span(total, pos);
				if (len > sz) begin
					st = pos;
					sz = len;
				end
			end
			r.found = (sz > 0);
			if (sz == 0)
				st = 0;
		end
		r.tlv_start = OUT_W'(st);
		r.tlv_size  = OUT_W'(sz);
		return r;
	endfunction

	function automatic row_t wr_row(logic [2:0] sel, logic [31:0] value);
		row_t r;
		r.is_write = 1'b1;
		r.reg_sel  = sel;
		r.wdata    = value;
		r.req      = '0;
		r.typed    = 1'b0;
		r.result   = '0;
		return r;
	endfunction

	function automatic row_t rq_row(logic [7:0] b, logic last);
		row_t r;
		r = wr_row(REG_AREA_START, '0);
		r.is_write = 1'b0;
		r.req.data_byte = b;
		r.req.last_byte = last;
		return r;
	endfunction

	function automatic row_t rq_exp(logic [7:0] b, logic f, int s, int z);
		row_t r;
		r = rq_row(b, 1'b1);
		r.typed = 1'b1;
		r.result.found = f;
		r.result.tlv_start = OUT_W'(s);
		r.result.tlv_size = OUT_W'(z);
		return r;
	endfunction

	function automatic int pick_area_len();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(24, 1);
		if (r < 96)
			return $urandom_range(80, 25);
		return $urandom_range(256, 81);
	endfunction

	// mostly tlv chains after an optional junk prefix, some pure noise
	task automatic build_area(input int n);
		int unsigned tw;
		int unsigned lw;
		int unsigned vlen;
		int unsigned pre;
		int unsigned k;
		int unsigned r;
		area_bytes.delete();
		tw = field_bytes(cfg_tw);
		lw = field_bytes(cfg_lw);
		if ($urandom_range(99) < 30) begin
			repeat (n) area_bytes.push_back(8'($urandom));
		end else begin
			pre = ($urandom_range(1) != 0) ? 0 : $urandom_range(5, 1);
			repeat (pre) area_bytes.push_back(8'($urandom));
			while (area_bytes.size() < n) begin
				repeat (tw) area_bytes.push_back(8'($urandom));
				r = $urandom_range(11);
				if (r == 0)
					vlen = 32'hFFFF_FFFF;
				else if (r == 1)
					vlen = $urandom;
				else
					vlen = $urandom_range(8, 0);
				if (lw < 4)
					vlen = vlen & ((32'd1 << (8 * lw)) - 1);
				for (k = 0; k < lw; k++) begin
					if (cfg_be)
						area_bytes.push_back(8'(vlen >> (8 * (lw - 1 - k))));
					else
						area_bytes.push_back(8'(vlen >> (8 * k)));
				end
				if (vlen <= 8)
					repeat (vlen) area_bytes.push_back(8'($urandom));
			end
			while (area_bytes.size() > n) void'(area_bytes.pop_back());
		end
	endtask

	task automatic offer_byte(input logic [7:0] b, input logic last, input bit typed,
			input out_item_t res);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last_byte: last};
		row_typed = typed;
		row_result = res;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (area_results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] sel, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			REG_AREA_START: cfg_start = int'($signed(value[CFG_W-1:0]));
			REG_AREA_SIZE:  cfg_size = int'($signed(value[CFG_W-1:0]));
			REG_TAG_WIDTH:  cfg_tw = value[1:0];
			REG_LEN_WIDTH:  cfg_lw = value[1:0];
			REG_BIG_ENDIAN: cfg_be = value[0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (bytes_held < STORE_DEPTH) begin
					byte_mirror[bytes_held] = in_data.data_byte;
					bytes_held++;
				end
				if (in_data.last_byte) begin
					want = locate_area(bytes_held);
					bytes_held = 0;
					area_results_due.push_back(row_typed ? row_result : want);
				end
			end
			if (out_valid && !out_stall) begin
				if (area_results_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: found=%0d start=%0d size=%0d",
							out_data.found, out_data.tlv_start, out_data.tlv_size);
					mismatches++;
				end else begin
					want = area_results_due.pop_front();
					if (out_data.found !== want.found || out_data.tlv_start !== want.tlv_start
							|| out_data.tlv_size !== want.tlv_size) begin
						if (mismatches < 10)
							$display({"mismatch: expected found=%0d start=%0d size=%0d, ",
								"got found=%0d start=%0d size=%0d"},
								want.found, want.tlv_start, want.tlv_size,
								out_data.found, out_data.tlv_start, out_data.tlv_size);
						mismatches++;
					end
				end
			end
		end
	end

	// receiver side: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 25);
			end
		end
	end

	initial begin
		int p;
		int n;
		int k;
		int st;
		int sz;
		int phase_items;
		bit loaded;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		row_typed = 1'b0;
		row_result = '0;
		mismatches = 0;
		bytes_held = 0;
		cfg_start = -1;
		cfg_size = -1;
		cfg_tw = WCODE_ONE;
		cfg_lw = WCODE_ONE;
		cfg_be = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_rows = '{
			rq_exp(8'h00, 1'b0, 0, 0),
			rq_row(8'h01, 1'b0), rq_exp(8'h00, 1'b1, 0, 2),
			rq_row(8'hFF, 1'b0), rq_row(8'hFF, 1'b0), rq_exp(8'hFF, 1'b0, 0, 0),
			wr_row(REG_AREA_START, 32'd0), wr_row(REG_AREA_SIZE, 32'd0),
			rq_exp(8'h55, 1'b1, 0, 0),
			// fixed start equal to the data size
			wr_row(REG_AREA_START, 32'd1), wr_row(REG_AREA_SIZE, 32'hFFFF_FFFF),
			rq_exp(8'hAA, 1'b1, 1, 0),
			wr_row(REG_AREA_START, 32'd4096), wr_row(REG_AREA_SIZE, 32'd4096),
			rq_exp(8'h12, 1'b0, 0, 0),
			wr_row(REG_AREA_SIZE, 32'hFFFF_E000),
			rq_exp(8'h00, 1'b0, 0, 0),
			// four-byte fields via code 3, little-endian length
			wr_row(REG_AREA_START, 32'hFFFF_E000), wr_row(REG_TAG_WIDTH, 32'd3),
			wr_row(REG_LEN_WIDTH, 32'd3), wr_row(REG_BIG_ENDIAN, 32'd0),
			rq_row(8'hFF, 1'b0), rq_row(8'h00, 1'b0), rq_row(8'hFF, 1'b0), rq_row(8'h00, 1'b0),
			rq_row(8'h01, 1'b0), rq_row(8'h00, 1'b0), rq_row(8'h00, 1'b0), rq_row(8'h00, 1'b0),
			rq_exp(8'hAB, 1'b1, 0, 9),
			wr_row(REG_TAG_WIDTH, 32'(WCODE_TWO)), wr_row(REG_LEN_WIDTH, 32'(WCODE_TWO)),
			wr_row(REG_BIG_ENDIAN, 32'd1), wr_row(REG_AREA_START, 32'd2),
			rq_row(8'hFF, 1'b0), rq_row(8'hFF, 1'b0), rq_row(8'h00, 1'b0),
			rq_row(8'h00, 1'b0), rq_row(8'h00, 1'b0), rq_row(8'h01, 1'b0),
			rq_exp(8'h7F, 1'b1, 2, 5)
		};

		loaded = 1'b0;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_write) begin
				if (loaded) begin
					drain();
					loaded = 1'b0;
				end
				reg_write(dir_rows[r].reg_sel, dir_rows[r].wdata);
			end else begin
				offer_byte(dir_rows[r].req.data_byte, dir_rows[r].req.last_byte,
					dir_rows[r].typed, dir_rows[r].result);
				loaded = 1'b1;
			end
		end
		drain();

		for (p = 0; p < 14; p++) begin
			quiet = (p == 3);
			k = $urandom_range(9);
			if (k < 3)
				st = -1;
			else if (k == 3)
				st = -int'($urandom_range(8192, 2));
			else if (k < 8)
				st = $urandom_range(12, 0);
			else if (k == 8)
				st = $urandom_range(300, 13);
			else
				st = $urandom_range(8191, 301);
			k = $urandom_range(9);
			if (k < 4)
				sz = (k == 0) ? -int'($urandom_range(8192, 2)) : -1;
			else if (k < 8)
				sz = $urandom_range(40, 0);
			else if (k == 8)
				sz = $urandom_range(300, 41);
			else
				sz = $urandom_range(8191, 301);
			if (p == 1) begin
				st = 4096;
				sz = 4096;
			end else if (p == 2) begin
				st = -8192;
				sz = 8191;
			end else if (p == 4) begin
				st = 8191;
				sz = -8192;
			end
			reg_write(REG_AREA_START, 32'(st));
			reg_write(REG_AREA_SIZE, 32'(sz));
			reg_write(REG_TAG_WIDTH, 32'($urandom_range(3)));
			reg_write(REG_LEN_WIDTH, 32'($urandom_range(3)));
			reg_write(REG_BIG_ENDIAN, 32'($urandom_range(1)));
			if (p == 6)
				hold_req = 1'b1;
			phase_items = 0;
			while (phase_items < 40) begin
				if (phase_items == 0 && p == 5)
					n = 270;
				else if (phase_items == 0 && p == 9)
					n = STORE_DEPTH;
				else if (p == 6)
					n = $urandom_range(24, 1);
				else
					n = pick_area_len();
				build_area(n);
				for (k = 0; k < n; k++)
					offer_byte(area_bytes[k], k == n - 1, 1'b0, '0);
				phase_items += n;
			end
			drain();
		end

		quiet = 1'b0;
		repeat (50) @(negedge clk);
		if (mismatches == 0 && area_results_due.size() == 0)
			$display("[tlv_area_locator] OK");
		else
			$display("[tlv_area_locator] ERROR");
		$finish;
	end

endmodule
